@@ sv/assert_macros.svh @@
// Assertion macros shared by the bounded array list engine RTL.
// No dependencies; expects a clock named clock and a reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BALE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bale assertion failed");

// next-cycle implication
`define BALE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bale assertion failed");

`endif

@@ sv/bale_pkg.sv @@
// Package for the bounded array list engine: sizes, action codes, beat structs.
// No dependencies.
package bale_pkg;

   localparam int DEPTH     = 64;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int WIDE_W    = (CNT_W > 6) ? CNT_W : 6;
   localparam int LEN_EXT_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int FI_EXT_W  = (IDX_W > 7) ? IDX_W : 7;

   typedef enum logic [3:0] {
      ACT_APPEND      = 4'd0,
      ACT_INSERT      = 4'd1,
      ACT_REMOVE_AT   = 4'd2,
      ACT_GET         = 4'd3,
      ACT_SET         = 4'd4,
      ACT_INDEX_OF    = 4'd5,
      ACT_CONTAINS    = 4'd6,
      ACT_REMOVE_LAST = 4'd7,
      ACT_SWAP        = 4'd8,
      ACT_CLEAR       = 4'd9
   } act_type;

   typedef struct packed {
      act_type     action;
      logic [5:0]  position;
      logic [5:0]  position_b;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [31:0]      wdata;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             ok;
      logic [31:0]      read_value;
      logic [6:0]       found_index;
      logic [CNT_W-1:0] count;
   } seq_stat_type;

   function automatic logic [IDX_W-1:0] pos_to_idx(input logic [5:0] p);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(p);
      return w[IDX_W-1:0];
   endfunction

   function automatic logic [WIDE_W-1:0] pos_wide(input logic [5:0] p);
      return WIDE_W'(p);
   endfunction

   function automatic logic [WIDE_W-1:0] cnt_wide(input logic [CNT_W-1:0] c);
      return WIDE_W'(c);
   endfunction

   function automatic logic [6:0] cnt_to_len(input logic [CNT_W-1:0] c);
      logic [LEN_EXT_W-1:0] w;
      w = LEN_EXT_W'(c);
      return w[6:0];
   endfunction

   function automatic logic [6:0] idx_to_fi(input logic [IDX_W-1:0] i);
      logic [FI_EXT_W-1:0] w;
      w = FI_EXT_W'(i);
      return w[6:0];
   endfunction

endpackage

@@ sv/bounded_array_list_engine_core.sv @@
// Top level of the bounded array list engine: request capture, sequencer,
// entry store and result register. Depends on bale_pkg, bale_seq, bale_ram, assert_macros.svh.
//
// Usage: drive req_* and raise start; the request beat is taken at a clock
// edge with start high and busy low. busy stays high until the sequencer is
// done. Exactly one result beat follows each request: rsp_strobe is high for
// one cycle with rsp_ok, rsp_read_value, rsp_found_index, rsp_length and
// rsp_full_res valid in that cycle. The receiver cannot stall; the result is
// simply presented for that one cycle.
// Work per action, with n = list length: append, set, clear, bad index and
//   unused code need no walk; get reads one entry; swap reads both and writes
//   them back; insert at p < n first shifts the tail up; remove_at shifts the
//   tail down unless p is the last entry; index_of/contains stop at the first
//   match, scan all n when absent and none on an empty list; remove_last_match
//   scans all n, then shifts the tail down when the last match is not last.
// The next request may be taken in the strobe cycle. Each step of a shift or
// search uses the single store port pair (one read, one write).
// Reset empties the list; entry contents are not cleared and no pass is needed.
`include "assert_macros.svh"
module bounded_array_list_engine_core
   import bale_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_action,
   input  logic [5:0]         req_position,
   input  logic [5:0]         req_position_b,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic signed [31:0] rsp_read_value,
   output logic signed [6:0]  rsp_found_index,
   output logic [6:0]         rsp_length,
   output logic               rsp_full_res
);

   req_type      req_ff;
   ram_req_type  ram_req;
   seq_stat_type stat;
   logic [31:0]  rdata;
   logic         accept;

   logic         rsp_strobe_ff;
   logic         rsp_ok_ff;
   logic [31:0]  rsp_read_value_ff;
   logic [6:0]   rsp_found_index_ff;
   logic [6:0]   rsp_length_ff;
   logic         rsp_full_res_ff;

   assign busy   = stat.busy;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= '{action: act_type'(req_action), position: req_position,
                     position_b: req_position_b, value: req_value};
      end
   end

   bale_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .go      (accept),
      .req     (req_ff),
      .rdata   (rdata),
      .ram_req (ram_req),
      .stat    (stat)
   );

   bale_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stat.done;
      end
      if (stat.done) begin
         rsp_ok_ff          <= stat.ok;
         rsp_read_value_ff  <= stat.read_value;
         rsp_found_index_ff <= stat.found_index;
         rsp_length_ff      <= cnt_to_len(stat.count);
         rsp_full_res_ff    <= (stat.count == CNT_W'(DEPTH));
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_read_value  = $signed(rsp_read_value_ff);
   assign rsp_found_index = $signed(rsp_found_index_ff);
   assign rsp_length      = rsp_length_ff;
   assign rsp_full_res    = rsp_full_res_ff;

   `BALE_ASSERT_NEXT(a_accept_busy, accept, busy)
   `BALE_ASSERT_NOW(a_strobe_after_busy, rsp_strobe, $past(busy))
   `BALE_ASSERT_NOW(a_count_bound, stat.busy, stat.count <= CNT_W'(DEPTH))

endmodule

@@ sv/bale_ram.sv @@
// Entry store: one write port, one read port with registered read data.
// Depends on bale_pkg.
module bale_ram
   import bale_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output logic [31:0] rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      rdata_ff <= mem[ram_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/bale_seq.sv @@
// Sequencer for the list engine: decodes a request, walks the store with the
// shared compare/move datapath and builds the result. Depends on bale_pkg.
module bale_seq
   import bale_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  req_type      req,
   input  logic [31:0]  rdata,
   output ram_req_type  ram_req,
   output seq_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_MOVE, S_DRAIN, S_INS_FIN, S_GET,
      S_SCAN, S_SCAN_END, S_SW1, S_SW2, S_SW3, S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] end_ff, end_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic             pend_ff, pend_in;
   logic             dir_up_ff, dir_up_in;
   logic             hit_vld_ff, hit_vld_in;
   logic             scan_last_ff, scan_last_in;
   logic             ok_ff, ok_in;
   logic [31:0]      rd_ff, rd_in;
   logic [6:0]       fi_ff, fi_in;
   logic [31:0]      tmp_ff, tmp_in;

   logic [IDX_W-1:0] pa_idx, pb_idx, rem_idx;
   logic [CNT_W-1:0] cnt_m1;
   logic             not_full, pa_in_rng, pb_in_rng, match, last_hit, do_remove;

   assign pa_idx    = pos_to_idx(req.position);
   assign pb_idx    = pos_to_idx(req.position_b);
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign pa_in_rng = (pos_wide(req.position) < cnt_wide(count_ff));
   assign pb_in_rng = (pos_wide(req.position_b) < cnt_wide(count_ff));
   assign match     = pend_ff && (rdata == req.value);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      prev_in      = prev_ff;
      hit_in       = hit_ff;
      pend_in      = pend_ff;
      dir_up_in    = dir_up_ff;
      hit_vld_in   = hit_vld_ff;
      scan_last_in = scan_last_ff;
      ok_in        = ok_ff;
      rd_in        = rd_ff;
      fi_in        = fi_ff;
      tmp_in       = tmp_ff;
      ram_req      = '{we: 1'b0, waddr: pa_idx, wdata: req.value, raddr: cur_ff};
      rem_idx      = pa_idx;
      do_remove    = 1'b0;
      last_hit     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            ok_in    = 1'b0;
            rd_in    = '0;
            fi_in    = '1;
            pend_in  = 1'b0;
            state_in = S_RESP;
            unique case (req.action)
               ACT_APPEND: begin
                  if (not_full) begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = count_ff[IDX_W-1:0];
                     count_in      = count_ff + CNT_W'(1);
                     ok_in         = 1'b1;
                  end
               end
               ACT_INSERT: begin
                  if (not_full && (pos_wide(req.position) <= cnt_wide(count_ff))) begin
                     if (pos_wide(req.position) == cnt_wide(count_ff)) begin
                        state_in = S_INS_FIN;
                     end else begin
                        cur_in    = cnt_m1[IDX_W-1:0];
                        end_in    = pa_idx;
                        dir_up_in = 1'b0;
                        state_in  = S_MOVE;
                     end
                  end
               end
               ACT_REMOVE_AT: begin
                  if (pa_in_rng) begin
                     do_remove = 1'b1;
                  end
               end
               ACT_GET: begin
                  if (pa_in_rng) begin
                     ram_req.raddr = pa_idx;
                     state_in      = S_GET;
                  end else begin
                     rd_in = '1;
                  end
               end
               ACT_SET: begin
                  if (pa_in_rng) begin
                     ram_req.we = 1'b1;
                     ok_in      = 1'b1;
                  end
               end
               ACT_INDEX_OF, ACT_CONTAINS, ACT_REMOVE_LAST: begin
                  if (count_ff != '0) begin
                     cur_in       = '0;
                     end_in       = cnt_m1[IDX_W-1:0];
                     hit_vld_in   = 1'b0;
                     scan_last_in = (req.action == ACT_REMOVE_LAST);
                     state_in     = S_SCAN;
                  end
               end
               ACT_SWAP: begin
                  if (pa_in_rng && pb_in_rng) begin
                     ram_req.raddr = pa_idx;
                     state_in      = S_SW1;
                  end
               end
               ACT_CLEAR: begin
                  count_in = '0;
                  ok_in    = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_MOVE: begin
            ram_req.raddr = cur_ff;
            ram_req.we    = pend_ff;
            ram_req.waddr = dir_up_ff ? (prev_ff - IDX_W'(1)) : (prev_ff + IDX_W'(1));
            ram_req.wdata = rdata;
            prev_in       = cur_ff;
            pend_in       = 1'b1;
            if (cur_ff == end_ff) begin
               state_in = S_DRAIN;
            end else begin
               cur_in = dir_up_ff ? (cur_ff + IDX_W'(1)) : (cur_ff - IDX_W'(1));
            end
         end
         S_DRAIN: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = dir_up_ff ? (prev_ff - IDX_W'(1)) : (prev_ff + IDX_W'(1));
            ram_req.wdata = rdata;
            pend_in       = 1'b0;
            if (dir_up_ff) begin
               count_in = cnt_m1;
               ok_in    = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_INS_FIN;
            end
         end
         S_INS_FIN: begin
            ram_req.we = 1'b1;
            count_in   = count_ff + CNT_W'(1);
            ok_in      = 1'b1;
            state_in   = S_RESP;
         end
         S_GET: begin
            rd_in    = rdata;
            ok_in    = 1'b1;
            state_in = S_RESP;
         end
         S_SCAN: begin
            ram_req.raddr = cur_ff;
            prev_in       = cur_ff;
            pend_in       = 1'b1;
            if (match && !scan_last_ff) begin
               ok_in    = 1'b1;
               fi_in    = (req.action == ACT_INDEX_OF) ? idx_to_fi(prev_ff) : '1;
               state_in = S_RESP;
            end else begin
               if (match) begin
                  hit_in     = prev_ff;
                  hit_vld_in = 1'b1;
               end
               if (cur_ff == end_ff) begin
                  state_in = S_SCAN_END;
               end else begin
                  cur_in = cur_ff + IDX_W'(1);
               end
            end
         end
         S_SCAN_END: begin
            pend_in  = 1'b0;
            state_in = S_RESP;
            if (!scan_last_ff) begin
               if (match) begin
                  ok_in = 1'b1;
                  fi_in = (req.action == ACT_INDEX_OF) ? idx_to_fi(prev_ff) : '1;
               end
            end else begin
               last_hit  = match || hit_vld_ff;
               rem_idx   = match ? prev_ff : hit_ff;
               do_remove = last_hit;
            end
         end
         S_SW1: begin
            ram_req.raddr = pb_idx;
            tmp_in        = rdata;
            state_in      = S_SW2;
         end
         S_SW2: begin
            ram_req.we    = 1'b1;
            ram_req.wdata = rdata;
            state_in      = S_SW3;
         end
         S_SW3: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = pb_idx;
            ram_req.wdata = tmp_ff;
            ok_in         = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // removal: last entry just shrinks, otherwise shift the tail down
      if (do_remove) begin
         pend_in = 1'b0;
         if ((CNT_W'(rem_idx) + CNT_W'(1)) == count_ff) begin
            count_in = cnt_m1;
            ok_in    = 1'b1;
            state_in = S_RESP;
         end else begin
            cur_in    = rem_idx + IDX_W'(1);
            end_in    = cnt_m1[IDX_W-1:0];
            dir_up_in = 1'b1;
            state_in  = S_MOVE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      cur_ff       <= cur_in;
      end_ff       <= end_in;
      prev_ff      <= prev_in;
      hit_ff       <= hit_in;
      dir_up_ff    <= dir_up_in;
      hit_vld_ff   <= hit_vld_in;
      scan_last_ff <= scan_last_in;
      ok_ff        <= ok_in;
      rd_ff        <= rd_in;
      fi_ff        <= fi_in;
      tmp_ff       <= tmp_in;
   end

   assign stat = '{busy: (state_ff != S_IDLE), done: (state_ff == S_RESP), ok: ok_ff,
                   read_value: rd_ff, found_index: fi_ff, count: count_ff};

endmodule
